// ===== design/tts_pkg.sv =====
// shared types and constants for the tridiagonal solver
package tts_pkg;

   localparam int QW = 32;
   localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [QW-1:0] sub_diag;
      logic signed [QW-1:0] main_diag;
      logic signed [QW-1:0] super_diag;
      logic signed [QW-1:0] rhs;
      logic                 last_row;
   } req_type;

   typedef struct packed {
      logic signed [QW-1:0] solution;
      logic [5:0]           row_index;
      logic                 last_out;
      logic                 pivot_error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FWD_DIV,
      ST_FWD_MUL,
      ST_FWD_WR,
      ST_BK_RD,
      ST_BK_WAIT,
      ST_BK_MUL,
      ST_BK_DIV,
      ST_BK_WR,
      ST_OUT_RD,
      ST_BK_OUT
   } state_type;

   // saturate a 64-bit signed value to 32 bits
   function automatic logic signed [QW:0] sat64(input logic signed [63:0] v);
      logic signed [QW:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) r = {1'b1, Q_MAX};
      else if (v < -64'sh0000_0000_8000_0000) r = {1'b1, Q_MIN};
      else r = {1'b0, v[QW-1:0]};
      return r;
   endfunction

endpackage

// ===== design/tts_if.sv =====
// valid/ready channel interfaces for the solver
interface tts_req_if import tts_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tts_rsp_if import tts_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== design/tts_ram.sv =====
// generic single-port-write ram with registered read
module tts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== design/tts_div.sv =====
// iterative Q16.16 divider, one quotient bit per cycle, saturating
module tts_div import tts_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [QW-1:0] num,
   input  logic signed [QW-1:0] den,
   output logic                 done,
   output logic signed [QW-1:0] quot,
   output logic                 sat
);
   // |num|<<16 is 48 bits, quotient up to 48 bits
   logic [47:0] rem_ff, rem_in;
   logic [47:0] q_ff, q_in;
   logic [31:0] dv_ff, dv_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        neg_ff, neg_in;
   logic        zero_ff, zero_in;
   logic        nneg_ff, nneg_in;
   logic        done_ff, done_in;
   logic [48:0] trial;
   logic [47:0] shifted;
   logic signed [63:0] sq;
   logic signed [QW:0] st;

   always_comb begin
      rem_in = rem_ff; q_in = q_ff; dv_in = dv_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; neg_in = neg_ff; zero_in = zero_ff; nneg_in = nneg_ff;
      done_in = 1'b0;
      shifted = {rem_ff[46:0], q_ff[47]};
      trial = {1'b0, shifted} - {17'd0, dv_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd48;
         rem_in  = '0;
         q_in    = {(num[QW-1] ? 32'(-num) : 32'(num)), 16'd0};
         dv_in   = den[QW-1] ? 32'(-den) : 32'(den);
         neg_in  = num[QW-1] ^ den[QW-1];
         zero_in = (den == '0);
         nneg_in = ~num[QW-1];
      end else if (busy_ff) begin
         if (!trial[48]) begin
            rem_in = trial[47:0];
            q_in   = {q_ff[46:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in   = {q_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in; q_ff <= q_in; dv_ff <= dv_in; cnt_ff <= cnt_in;
      neg_ff <= neg_in; zero_ff <= zero_in; nneg_ff <= nneg_in;
   end

   always_comb begin
      sq = neg_ff ? -$signed({16'd0, q_ff}) : $signed({16'd0, q_ff});
      st = sat64(sq);
      if (zero_ff) begin
         quot = nneg_ff ? Q_MAX : Q_MIN;
         sat  = 1'b1;
      end else begin
         quot = st[QW-1:0];
         sat  = st[QW];
      end
   end
   assign done = done_ff;
endmodule

// ===== design/tts_front.sv =====
// front end: accepts rows and queues them for the solver core
module tts_front import tts_pkg::*; #(
   parameter int QDEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   tts_req_if.sink   req,
   output logic      q_valid,
   output req_type   q_data,
   input  logic      q_pop
);
   localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   req_type        buf_ff [QDEPTH];
   logic [AW-1:0]  wp_ff, rp_ff;
   logic [AW:0]    cnt_ff;
   logic           push;

   assign req.ready = (cnt_ff != (AW+1)'(QDEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != '0);
   assign q_data    = buf_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(QDEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (q_pop) rp_ff <= (rp_ff == AW'(QDEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(q_pop);
      end
      if (push) buf_ff[wp_ff] <= req.data;
   end
endmodule

// ===== design/tts_core.sv =====
// back end: forward elimination per row and back substitution
module tts_core import tts_pkg::*; #(
   parameter int MAX_ROWS = 64
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  req_type   q_data,
   output logic      q_pop,
   tts_rsp_if.source rsp
);
   localparam int AW = $clog2(MAX_ROWS);

   state_type state_ff, state_in;
   logic [AW:0]   rows_ff, rows_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] top_ff;
   logic          err_ff, err_in;
   req_type       row_ff;
   logic signed [QW-1:0] pd_ff, pr_ff, pc_ff;  // previous row values
   logic signed [QW-1:0] m_ff, x_ff, d_ff;
   logic signed [63:0]   p1_ff, p2_ff;
   logic                 rsp_v_ff;
   rsp_type              rsp_ff;

   // ram ports
   logic          wr_en, x_wr;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [QW-1:0] wd_d, wd_r, wd_c, wd_rx, rd_d, rd_r, rd_c;

   // divider
   logic                 dv_start, dv_done, dv_sat;
   logic signed [QW-1:0] dv_num, dv_den, dv_q;

   // solved values overwrite the rhs entries once those are consumed
   assign wd_rx = x_wr ? x_ff : wd_r;

   tts_ram #(.WIDTH(QW), .DEPTH(MAX_ROWS)) u_diag (.clock, .wr_en, .wr_addr,
      .wr_data(wd_d), .rd_addr, .rd_data(rd_d));
   tts_ram #(.WIDTH(QW), .DEPTH(MAX_ROWS)) u_rhs (.clock, .wr_en(wr_en || x_wr),
      .wr_addr, .wr_data(wd_rx), .rd_addr, .rd_data(rd_r));
   tts_ram #(.WIDTH(QW), .DEPTH(MAX_ROWS)) u_sup (.clock, .wr_en, .wr_addr,
      .wr_data(wd_c), .rd_addr, .rd_data(rd_c));

   tts_div u_div (.clock, .reset, .start(dv_start), .num(dv_num), .den(dv_den),
      .done(dv_done), .quot(dv_q), .sat(dv_sat));

   // floor(p/65536) is an arithmetic shift
   function automatic logic signed [QW:0] qfix(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p >>> 16;
      return sat64(s);
   endfunction

   logic signed [QW:0] mul1, mul2, sub1, sub2;
   logic               is_first, is_last;
   logic               out_free;

   assign mul1 = qfix(p1_ff);
   assign mul2 = qfix(p2_ff);
   assign sub1 = sat64(64'(row_ff.main_diag) - 64'($signed(mul1[QW-1:0])));
   assign sub2 = sat64(64'(row_ff.rhs) - 64'($signed(mul2[QW-1:0])));
   assign is_first = (rows_ff == '0);
   assign is_last  = row_ff.last_row || (rows_ff == (AW+1)'(MAX_ROWS-1));
   assign out_free = !rsp_v_ff || rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (q_valid) state_in = ST_FWD_DIV;
         ST_FWD_DIV: begin
            if (is_first) state_in = ST_FWD_WR;
            else if (dv_done) state_in = ST_FWD_MUL;
         end
         ST_FWD_MUL: state_in = ST_FWD_WR;
         ST_FWD_WR:  state_in = is_last ? ST_BK_DIV : ST_IDLE;
         ST_BK_RD:   state_in = ST_BK_WAIT;
         ST_BK_WAIT: state_in = ST_BK_MUL;
         ST_BK_MUL:  state_in = ST_BK_DIV;
         ST_BK_DIV:  if (dv_done) state_in = ST_BK_WR;
         ST_BK_WR:   state_in = (idx_ff == '0) ? ST_OUT_RD : ST_BK_RD;
         ST_OUT_RD:  state_in = ST_BK_OUT;
         ST_BK_OUT: begin
            if (out_free) state_in = (idx_ff == '0) ? ST_IDLE : ST_OUT_RD;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      q_pop    = (state_ff == ST_IDLE) && q_valid;
      rows_in  = rows_ff;
      idx_in   = idx_ff;
      err_in   = err_ff;
      wr_en    = 1'b0;
      x_wr     = 1'b0;
      wr_addr  = rows_ff[AW-1:0];
      wd_d     = is_first ? row_ff.main_diag : sub1[QW-1:0];
      wd_r     = is_first ? row_ff.rhs : sub2[QW-1:0];
      wd_c     = row_ff.super_diag;
      rd_addr  = idx_ff;
      dv_start = 1'b0;
      dv_num   = row_ff.sub_diag;
      dv_den   = pd_ff;
      case (state_ff)
         ST_IDLE: dv_start = q_valid && !is_first;
         ST_FWD_DIV: if (dv_done) err_in = err_ff | dv_sat;
         ST_FWD_WR: begin
            wr_en = 1'b1;
            if (!is_first) err_in = err_in | mul1[QW] | mul2[QW] | sub1[QW] | sub2[QW];
            if (is_last && !row_ff.last_row) err_in = 1'b1;
            idx_in = rows_ff[AW-1:0];
            rows_in = is_last ? '0 : rows_ff + 1'b1;
            dv_start = is_last;
            dv_num = wd_r;
            dv_den = wd_d;
         end
         ST_BK_MUL: begin
            err_in   = err_ff | mul1[QW] | sub1[QW];
            dv_start = 1'b1;
            dv_num   = sub1[QW-1:0];
            dv_den   = d_ff;
         end
         ST_BK_DIV: if (dv_done) err_in = err_ff | dv_sat;
         ST_BK_WR: begin
            x_wr    = 1'b1;
            wr_addr = idx_ff;
            // after index zero, read the solution back from the top
            idx_in  = (idx_ff == '0) ? top_ff : idx_ff - 1'b1;
         end
         ST_BK_OUT: begin
            if (out_free) begin
               idx_in = idx_ff - 1'b1;
               if (idx_ff == '0) err_in = 1'b0;
            end
         end
         default: ;
      endcase
      // pop happens in idle, is_first uses the row count at that time
      if (state_ff == ST_IDLE) begin
         dv_num = q_data.sub_diag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff  <= '0;
         err_ff   <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
         err_ff   <= err_in;
         if (state_ff == ST_BK_OUT && out_free) rsp_v_ff <= 1'b1;
         else if (rsp.ready) rsp_v_ff <= 1'b0;
      end
      idx_ff <= idx_in;
      if (q_pop) row_ff <= q_data;
      if (state_ff == ST_FWD_DIV && dv_done) m_ff <= dv_q;
      if (state_ff == ST_FWD_MUL) begin
         p1_ff <= 64'(m_ff) * 64'(pc_ff);
         p2_ff <= 64'(m_ff) * 64'(pr_ff);
      end
      if (state_ff == ST_FWD_WR) begin
         pd_ff <= wd_d; pr_ff <= wd_r; pc_ff <= wd_c;
         top_ff <= rows_ff[AW-1:0];
      end
      // back substitution: t = rhs' - super*x, sub1 reuses row_ff.main_diag
      if (state_ff == ST_BK_WAIT) begin
         p1_ff <= 64'($signed(rd_c)) * 64'(x_ff);
         row_ff.main_diag <= rd_r;
         d_ff <= rd_d;
      end
      if (state_ff == ST_BK_DIV && dv_done) x_ff <= dv_q;
      if (state_ff == ST_BK_OUT && out_free) begin
         rsp_ff.solution    <= rd_r;
         rsp_ff.row_index   <= 6'(idx_ff);
         rsp_ff.last_out    <= (idx_ff == '0);
         rsp_ff.pivot_error <= err_ff;
      end
   end

   assign rsp.valid = rsp_v_ff;
   assign rsp.data  = rsp_ff;
endmodule

// ===== design/tridiagonal_thomas_solver_unit.sv =====
// top level of the tridiagonal (thomas) solver
//  channel | dir | payload
//  req     | in  | sub_diag, main_diag, super_diag, rhs, last_row
//  rsp     | out | solution, row_index, last_out, pivot_error
// each row after the first waits on the 48-step divider; row zero skips the division
// back substitution then divides directly for the last unknown and reads, multiplies, divides for each other one
// the solved values are read back and sent one at a time, each read before it is sent, index n-1 first
// synchronous active-high reset clears control, row count and error flag
// a two-entry queue lets rows arrive while the core is busy; a stalled
// result holds the core in its output state
module tridiagonal_thomas_solver_unit import tts_pkg::*; #(
   parameter int MAX_ROWS = 64
) (
   input  logic      clock,
   input  logic      reset,
   tts_req_if.sink   req,
   tts_rsp_if.source rsp
);
   logic    q_valid, q_pop;
   req_type q_data;

   tts_front #(.QDEPTH(2)) u_front (.clock, .reset, .req, .q_valid, .q_data, .q_pop);
   tts_core #(.MAX_ROWS(MAX_ROWS)) u_core (.clock, .reset, .q_valid, .q_data,
      .q_pop, .rsp);
endmodule
